### rtl/dppm_pkg.sv
// Shared types and constants for the debounced pulse period meter.
package dppm_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned PHASE_W = 2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic              op;
        logic              pin_level;
        logic [TIME_W-1:0] time_us;
        logic [TIME_W-1:0] time_ms;
    } in_word_t;

    typedef struct packed {
        logic [TIME_W-1:0]  period_ms;
        logic               new_data;
        logic [TIME_W-1:0]  edge_count;
        logic [PHASE_W-1:0] phase;
    } out_word_t;

endpackage

### rtl/dppm_in_if.sv
// Valid/ready channel that carries pin sample and restart words.
interface dppm_in_if;
    import dppm_pkg::*;

    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/dppm_out_if.sv
// Valid/ready channel that carries measurement result words.
interface dppm_out_if;
    import dppm_pkg::*;

    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/debounced_pulse_period_meter.sv
// Debounced pulse period meter: one result word for every accepted sample or restart word.
//
// The block takes one word per clock cycle while its input is ready and registers its
// result in the output register on acceptance. The whole debounce step (one
// wrapping subtract and compare against filter_us, the phase update and the
// edge counter increment) sits between the measurement state registers and
// the result register. The input is ready whenever the result register is
// empty or its word is taken in the same cycle, so with a ready consumer the
// block sustains one word per cycle. All time differences and the edge count
// wrap modulo 2^32. A restart word clears the measurement state and keeps
// filter_us. filter_us must be written only while no word is in flight (not enforced).
module debounced_pulse_period_meter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dppm_pkg::TIME_W-1:0]    cfg_wdata,
    dppm_in_if.sink                        sample,
    dppm_out_if.source                     result
);
    import dppm_pkg::*;

    typedef enum logic [PHASE_W-1:0] {
        PH_WAIT_HIGH = 2'd0,
        PH_CONF_HIGH = 2'd1,
        PH_WAIT_LOW  = 2'd2,
        PH_CONF_LOW  = 2'd3
    } phase_t;

    logic [TIME_W-1:0] filter_us_reg;
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [TIME_W-1:0] change_time_reg;
    logic [TIME_W-1:0] change_time_next;
    logic [TIME_W-1:0] last_edge_reg;
    logic [TIME_W-1:0] last_edge_next;
    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] period_next;
    logic              armed_reg;
    logic              armed_next;
    logic              fresh_reg;
    logic              fresh_next;
    logic [TIME_W-1:0] edge_total_reg;
    logic [TIME_W-1:0] edge_total_next;
    logic              out_valid_reg;
    out_word_t         out_word_reg;

    logic              accept;
    logic              held;

    assign sample.ready = !out_valid_reg || result.ready;
    assign accept = sample.valid && sample.ready;
    assign result.valid = out_valid_reg;
    assign result.data = out_word_reg;

    assign held = (sample.data.time_us - change_time_reg) >= filter_us_reg;

    always_comb
    begin
        phase_next = phase_reg;
        change_time_next = change_time_reg;
        last_edge_next = last_edge_reg;
        period_next = period_reg;
        armed_next = armed_reg;
        fresh_next = fresh_reg;
        edge_total_next = edge_total_reg;
        if (sample.data.op == OP_RESTART)
        begin
            phase_next = PH_WAIT_HIGH;
            change_time_next = '0;
            last_edge_next = '0;
            period_next = '0;
            armed_next = 1'b0;
            fresh_next = 1'b0;
            edge_total_next = '0;
        end
        else
        begin
            case (phase_reg)
                PH_WAIT_HIGH:
                begin
                    if (sample.data.pin_level)
                    begin
                        change_time_next = sample.data.time_us;
                        period_next = sample.data.time_ms - last_edge_reg;
                        last_edge_next = sample.data.time_ms;
                        phase_next = PH_CONF_HIGH;
                    end
                end
                PH_CONF_HIGH:
                begin
                    if (!sample.data.pin_level)
                    begin
                        phase_next = PH_WAIT_HIGH;
                    end
                    else if (held)
                    begin
                        if (!armed_reg)
                        begin
                            armed_next = 1'b1;
                        end
                        else
                        begin
                            fresh_next = 1'b1;
                            edge_total_next = edge_total_reg + TIME_W'(1);
                        end
                        phase_next = PH_WAIT_LOW;
                    end
                end
                PH_WAIT_LOW:
                begin
                    if (!sample.data.pin_level)
                    begin
                        change_time_next = sample.data.time_us;
                        phase_next = PH_CONF_LOW;
                    end
                end
                PH_CONF_LOW:
                begin
                    if (sample.data.pin_level)
                    begin
                        phase_next = PH_WAIT_LOW;
                    end
                    else if (held)
                    begin
                        phase_next = PH_WAIT_HIGH;
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT_HIGH;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_us_reg <= '0;
            phase_reg <= PH_WAIT_HIGH;
            change_time_reg <= '0;
            last_edge_reg <= '0;
            period_reg <= '0;
            armed_reg <= 1'b0;
            fresh_reg <= 1'b0;
            edge_total_reg <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                filter_us_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                change_time_reg <= change_time_next;
                last_edge_reg <= last_edge_next;
                period_reg <= period_next;
                armed_reg <= armed_next;
                fresh_reg <= fresh_next;
                edge_total_reg <= edge_total_next;
                out_word_reg.period_ms <= period_next;
                out_word_reg.new_data <= fresh_next;
                out_word_reg.edge_count <= edge_total_next;
                out_word_reg.phase <= phase_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
